// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define ACPU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("acpu assertion failed");

// Check that a condition never holds at a clock edge out of reset.
`define ACPU_ASSERT_NEVER(name, expr) \
  `ACPU_ASSERT(name, !(expr))

`endif

// ===== rtl/acpu_pkg.sv =====
package acpu_pkg;

  // Field widths of one instruction and of the machine state
  localparam int unsigned OPCODE_W  = 5;
  localparam int unsigned OPERAND_W = 11;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned PC_W      = 11;

  // PC advance per executed instruction
  localparam logic [PC_W-1:0] PC_STEP = 11'd2;

  // Opcodes; any other code is an illegal instruction
  typedef enum logic [OPCODE_W-1:0] {
    OP_WM      = 5'h01,
    OP_RM      = 5'h02,
    OP_BR      = 5'h03,
    OP_RIO     = 5'h04,
    OP_WIO     = 5'h05,
    OP_WB      = 5'h06,
    OP_WIB     = 5'h07,
    OP_WIB_ALT = 5'h08,
    OP_WACC    = 5'h09,
    OP_RACC    = 5'h0B,
    OP_SWAP    = 5'h0E,
    OP_BRLT    = 5'h11,
    OP_BRGT    = 5'h12,
    OP_BRNE    = 5'h13,
    OP_BRE     = 5'h14,
    OP_SHR     = 5'h15,
    OP_SHL     = 5'h16,
    OP_XOR     = 5'h17,
    OP_NOT     = 5'h18,
    OP_OR      = 5'h19,
    OP_AND     = 5'h1A,
    OP_MUL     = 5'h1B,
    OP_SUB     = 5'h1D,
    OP_ADD     = 5'h1E,
    OP_EOP     = 5'h1F
  } op_e;

  // Result of one instruction, last field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic              error_out;
    logic              halt_out;
    logic              branch_taken;
    logic [PC_W-1:0]   next_pc;
    logic              overflow_out;
    logic              carry_out;
    logic              zero_out;
    logic [DATA_W-1:0] io_value;
    logic [DATA_W-1:0] buffer_value;
    logic [DATA_W-1:0] acc_value;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== rtl/acpu_ram.sv =====
module acpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read ports; a read of the same entry in the same cycle sees the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/accumulator_cpu_execute.sv =====
// Execute stage of an 8-bit accumulator machine. Each input transaction is
// one fetched instruction (opcode, operand); each output transaction is the
// full architectural state after that instruction. The data memory and the
// I/O buffer sit in synchronous RAMs: the read for an instruction is issued
// when it is accepted, and the instruction executes from the execute
// registers against the returned data, with a store from the instruction
// ahead forwarded when it hits the same entry. Throughput is one instruction
// per cycle while the output is not stalled; the output register lets the
// next instruction enter while a result waits. After reset the block
// sweeps both RAMs to zero, one entry per cycle, and accepts no instruction
// until the sweep ends. Once an EOP or an illegal opcode executes, the
// machine halts and later instructions only report the frozen state.
`include "assert_macros.svh"

module accumulator_cpu_execute #(
  parameter int unsigned MEM_DEPTH = 2048,
  parameter int unsigned IO_DEPTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] req_type, [15:5] operand
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] acc_value, [15:8] buffer_value, [23:16] io_value, [24] zero_out,
  // [25] carry_out, [26] overflow_out, [37:27] next_pc, [38] branch_taken,
  // [39] halt_out, [40] error_out, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned IAW = $clog2(IO_DEPTH);
  localparam int unsigned DW  = acpu_pkg::DATA_W;
  localparam int unsigned OW  = acpu_pkg::OPERAND_W;
  localparam int unsigned PW  = acpu_pkg::PC_W;

  // Reduce an operand modulo a depth by restoring steps (quotient < 256)
  function automatic logic [OW-1:0] fold_addr(input logic [OW-1:0] v,
                                              input int unsigned depth);
    logic [OW+7:0] r;
    logic [OW+7:0] dk;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      dk = (OW + 8)'(depth) << k;
      if (r >= dk) begin
        r = r - dk;
      end
    end
    return r[OW-1:0];
  endfunction

  // Architectural registers
  logic [DW-1:0] acc_q, acc_d;
  logic [DW-1:0] membuf_q, membuf_d;
  logic [DW-1:0] iobuf_q, iobuf_d;
  logic          zero_q, zero_d;
  logic          carry_q, carry_d;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] pc_q, pc_d;
  logic          halted_q, halted_d;

  // Execute stage
  logic                ex_valid_q, ex_valid_d;
  acpu_pkg::op_e       ex_op_q;
  logic [OW-1:0]       ex_opnd_q;
  logic [MAW-1:0]      ex_maddr_q;
  logic [IAW-1:0]      ex_iaddr_q;
  logic                ex_fire;

  // Store forwarding
  logic                fwd_mem_q, fwd_io_q;
  logic [DW-1:0]       fwd_mem_data_q, fwd_io_data_q;

  // Clearing sweep
  logic                clearing_q;
  logic [MAW-1:0]      clr_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  acpu_pkg::result_t   out_q;
  acpu_pkg::result_t   res;

  // RAM ports
  logic                in_accept;
  logic [OW-1:0]       in_opnd;
  logic [OW-1:0]       in_maddr_full, in_iaddr_full;
  logic [MAW-1:0]      in_maddr;
  logic [IAW-1:0]      in_iaddr;
  logic                mem_we, io_we;
  logic                mem_st, io_st;
  logic [MAW-1:0]      mem_waddr;
  logic [IAW-1:0]      io_waddr;
  logic [DW-1:0]       mem_wdata, io_wdata;
  logic [DW-1:0]       mem_rdata, io_rdata;
  logic [DW-1:0]       mem_val, io_val;

  // Execute results
  logic [2*DW-1:0]     product;
  logic [DW:0]         diff;
  logic [DW-1:0]       sum;
  logic                taken, err;

  // Handshake
  assign ex_fire       = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!ex_valid_q || ex_fire);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_opnd       = s_axis_tdata[15:5];
  assign in_maddr_full = fold_addr(in_opnd, MEM_DEPTH);
  assign in_iaddr_full = fold_addr(in_opnd, IO_DEPTH);
  assign in_maddr      = in_maddr_full[MAW-1:0];
  assign in_iaddr      = in_iaddr_full[IAW-1:0];

  // Stores from the executing instruction
  assign mem_st = ex_fire && !halted_q && (ex_op_q == acpu_pkg::OP_WM);
  assign io_st  = ex_fire && !halted_q && (ex_op_q == acpu_pkg::OP_WIO);

  // Share the write ports between the sweep and stores
  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
      io_we     = ({{(32-MAW){1'b0}}, clr_q} < 32'(IO_DEPTH));
      io_waddr  = clr_q[IAW-1:0];
      io_wdata  = '0;
    end else begin
      mem_we    = mem_st;
      mem_waddr = ex_maddr_q;
      mem_wdata = membuf_q;
      io_we     = io_st;
      io_waddr  = ex_iaddr_q;
      io_wdata  = iobuf_q;
    end
  end

  acpu_ram #(
    .WIDTH(DW),
    .DEPTH(MEM_DEPTH)
  ) u_data_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (in_accept),
    .raddr_i(in_maddr),
    .rdata_o(mem_rdata)
  );

  acpu_ram #(
    .WIDTH(DW),
    .DEPTH(IO_DEPTH)
  ) u_io_mem (
    .clk_i  (clk_i),
    .we_i   (io_we),
    .waddr_i(io_waddr),
    .wdata_i(io_wdata),
    .re_i   (in_accept),
    .raddr_i(in_iaddr),
    .rdata_o(io_rdata)
  );

  // Pick forwarded store data over stale RAM data
  assign mem_val = fwd_mem_q ? fwd_mem_data_q : mem_rdata;
  assign io_val  = fwd_io_q ? fwd_io_data_q : io_rdata;

  // Arithmetic shared by the ALU and compare-branch opcodes
  assign product = 16'(acc_q) * 16'(membuf_q);
  assign diff    = {1'b0, acc_q} - {1'b0, membuf_q};
  assign sum     = acc_q + membuf_q;

  // Execute one instruction against the current state
  always_comb begin
    acc_d    = acc_q;
    membuf_d = membuf_q;
    iobuf_d  = iobuf_q;
    zero_d   = zero_q;
    carry_d  = carry_q;
    ovf_d    = ovf_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    taken    = 1'b0;
    err      = 1'b0;
    if (ex_fire && !halted_q) begin
      pc_d = pc_q + acpu_pkg::PC_STEP;
      case (ex_op_q)
        acpu_pkg::OP_WM, acpu_pkg::OP_WIO: begin
        end
        acpu_pkg::OP_RM:   membuf_d = mem_val;
        acpu_pkg::OP_BR:   taken = 1'b1;
        acpu_pkg::OP_RIO:  iobuf_d = io_val;
        acpu_pkg::OP_WB:   membuf_d = ex_opnd_q[DW-1:0];
        acpu_pkg::OP_WIB, acpu_pkg::OP_WIB_ALT: iobuf_d = ex_opnd_q[DW-1:0];
        acpu_pkg::OP_WACC: acc_d = membuf_q;
        acpu_pkg::OP_RACC: membuf_d = acc_q;
        acpu_pkg::OP_SWAP: begin
          membuf_d = iobuf_q;
          iobuf_d  = membuf_q;
        end
        acpu_pkg::OP_BRLT, acpu_pkg::OP_BRGT, acpu_pkg::OP_BRNE,
        acpu_pkg::OP_BRE, acpu_pkg::OP_SUB: begin
          acc_d   = diff[DW-1:0];
          zero_d  = (diff[DW-1:0] == '0);
          carry_d = diff[DW];
          ovf_d   = 1'b0;
          case (ex_op_q)
            acpu_pkg::OP_BRLT: taken = diff[DW];
            acpu_pkg::OP_BRGT: taken = !diff[DW];
            acpu_pkg::OP_BRNE: taken = (diff[DW-1:0] != '0);
            acpu_pkg::OP_BRE:  taken = (diff[DW-1:0] == '0);
            default:           taken = 1'b0;
          endcase
        end
        acpu_pkg::OP_SHR: acc_d = acc_q >> 1;
        acpu_pkg::OP_SHL: acc_d = acc_q << 1;
        acpu_pkg::OP_XOR: acc_d = acc_q ^ membuf_q;
        acpu_pkg::OP_NOT: acc_d = ~acc_q;
        acpu_pkg::OP_OR:  acc_d = acc_q | membuf_q;
        acpu_pkg::OP_AND: acc_d = acc_q & membuf_q;
        acpu_pkg::OP_MUL: begin
          acc_d   = product[DW-1:0];
          zero_d  = (product == '0);
          carry_d = (product[2*DW-1:DW] != '0);
          ovf_d   = (product[2*DW-1:DW] != '0);
        end
        acpu_pkg::OP_ADD: begin
          acc_d   = sum;
          zero_d  = (sum == '0);
          carry_d = 1'b0;
          ovf_d   = 1'b0;
        end
        acpu_pkg::OP_EOP: halted_d = 1'b1;
        default: begin
          err      = 1'b1;
          halted_d = 1'b1;
        end
      endcase
      if (taken) begin
        pc_d = ex_opnd_q;
      end
    end
  end

  // Assemble the result of the executing instruction
  always_comb begin
    res              = '0;
    res.acc_value    = acc_d;
    res.buffer_value = membuf_d;
    res.io_value     = iobuf_d;
    res.zero_out     = zero_d;
    res.carry_out    = carry_d;
    res.overflow_out = ovf_d;
    res.next_pc      = pc_d;
    res.branch_taken = taken;
    res.halt_out     = halted_d;
    res.error_out    = err;
  end

  assign ex_valid_d  = in_accept || (ex_valid_q && !ex_fire);
  assign out_valid_d = ex_fire || (out_valid_q && !m_axis_tready);

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      membuf_q    <= '0;
      iobuf_q     <= '0;
      zero_q      <= 1'b0;
      carry_q     <= 1'b0;
      ovf_q       <= 1'b0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_mem_q   <= 1'b0;
      fwd_io_q    <= 1'b0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
    end else begin
      acc_q       <= acc_d;
      membuf_q    <= membuf_d;
      iobuf_q     <= iobuf_d;
      zero_q      <= zero_d;
      carry_q     <= carry_d;
      ovf_q       <= ovf_d;
      pc_q        <= pc_d;
      halted_q    <= halted_d;
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      // Advance the clearing sweep
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == MAW'(MEM_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      // Note a store that the new read cannot see yet
      if (in_accept) begin
        fwd_mem_q <= mem_st && (ex_maddr_q == in_maddr);
        fwd_io_q  <= io_st && (ex_iaddr_q == in_iaddr);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_op_q        <= acpu_pkg::op_e'(s_axis_tdata[4:0]);
      ex_opnd_q      <= in_opnd;
      ex_maddr_q     <= in_maddr;
      ex_iaddr_q     <= in_iaddr;
      fwd_mem_data_q <= membuf_q;
      fwd_io_data_q  <= iobuf_q;
    end
    if (ex_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Halt is sticky until reset
  `ACPU_ASSERT(halt_sticky_a, halted_q |=> halted_q)
  // An instruction waiting on the output is not lost
  `ACPU_ASSERT(ex_hold_a, (ex_valid_q && !ex_fire) |=> ex_valid_q)
  // An illegal opcode always reports a halt
  `ACPU_ASSERT_NEVER(err_no_halt_a, out_valid_q && out_q.error_out && !out_q.halt_out)
  // The sweep ends with the machine still in its reset state
  `ACPU_ASSERT(sweep_end_a, $fell(clearing_q) |-> ((pc_q == '0) && !halted_q))

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned MEM_WORDS      = 2048;
  localparam int unsigned IO_WORDS       = 32;
  localparam int unsigned ITEM_TARGET    = 750;
  localparam int unsigned HALTED_ITEMS   = 12;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Opcodes that the machine does not decode; each one halts it with an error
  localparam logic [acpu_pkg::OPCODE_W-1:0] UNUSED_OPS [7] =
    '{5'h00, 5'h0A, 5'h0C, 5'h0D, 5'h0F, 5'h10, 5'h1C};

  // Opcodes that run without halting: moves first, then compare-branches and ALU
  localparam int unsigned ALU_FIRST = 11;
  localparam acpu_pkg::op_e RUN_OPS [24] = '{
    acpu_pkg::OP_WM, acpu_pkg::OP_RM, acpu_pkg::OP_BR, acpu_pkg::OP_RIO,
    acpu_pkg::OP_WIO, acpu_pkg::OP_WB, acpu_pkg::OP_WIB, acpu_pkg::OP_WIB_ALT,
    acpu_pkg::OP_WACC, acpu_pkg::OP_RACC, acpu_pkg::OP_SWAP, acpu_pkg::OP_BRLT,
    acpu_pkg::OP_BRGT, acpu_pkg::OP_BRNE, acpu_pkg::OP_BRE, acpu_pkg::OP_SHR,
    acpu_pkg::OP_SHL, acpu_pkg::OP_XOR, acpu_pkg::OP_NOT, acpu_pkg::OP_OR,
    acpu_pkg::OP_AND, acpu_pkg::OP_MUL, acpu_pkg::OP_SUB, acpu_pkg::OP_ADD};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [4:0] req_type, [15:5] operand
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] acc_value, [15:8] buffer_value, [23:16] io_value, [24] zero_out,
  // [25] carry_out, [26] overflow_out, [37:27] next_pc, [38] branch_taken,
  // [39] halt_out, [40] error_out, [47:41] zero
  logic [47:0] m_axis_tdata;

  // Machine state tracker: executes each accepted instruction and queues the
  // state it should leave behind, then compares reported states in order
  class instr_scoreboard;
    bit [acpu_pkg::DATA_W-1:0] acc, mbr, iobr;
    bit                        zf, cf, vf, halted;
    bit [acpu_pkg::PC_W-1:0]   pc;
    bit [acpu_pkg::DATA_W-1:0] data_mem [MEM_WORDS];
    bit [acpu_pkg::DATA_W-1:0] io_mem [IO_WORDS];
    acpu_pkg::result_t         pending_state[$];
    int unsigned               fails;

    function void subtract();
      bit [acpu_pkg::DATA_W-1:0] diff;
      diff = acc - mbr;
      zf   = (diff == 0);
      cf   = (acc < mbr);
      vf   = 1'b0;
      acc  = diff;
    endfunction

    function void execute_instr(logic [15:0] d);
      logic [acpu_pkg::OPCODE_W-1:0]  code;
      logic [acpu_pkg::OPERAND_W-1:0] opnd;
      bit [2*acpu_pkg::DATA_W-1:0]    prod;
      bit [acpu_pkg::DATA_W-1:0]      tmp;
      bit                             taken, err;
      acpu_pkg::result_t              r;
      code  = d[acpu_pkg::OPCODE_W-1:0];
      opnd  = d[acpu_pkg::OPCODE_W +: acpu_pkg::OPERAND_W];
      taken = 1'b0;
      err   = 1'b0;
      if (!halted) begin
        pc = pc + acpu_pkg::PC_STEP;
        case (code)
          acpu_pkg::OP_WM:   data_mem[opnd] = mbr;
          acpu_pkg::OP_RM:   mbr = data_mem[opnd];
          acpu_pkg::OP_BR:   taken = 1'b1;
          acpu_pkg::OP_RIO:  iobr = io_mem[opnd[4:0]];
          acpu_pkg::OP_WIO:  io_mem[opnd[4:0]] = iobr;
          acpu_pkg::OP_WB:   mbr = opnd[7:0];
          acpu_pkg::OP_WIB, acpu_pkg::OP_WIB_ALT: iobr = opnd[7:0];
          acpu_pkg::OP_WACC: acc = mbr;
          acpu_pkg::OP_RACC: mbr = acc;
          acpu_pkg::OP_SWAP: begin
            tmp  = mbr;
            mbr  = iobr;
            iobr = tmp;
          end
          acpu_pkg::OP_BRLT: begin
            subtract();
            taken = cf;
          end
          acpu_pkg::OP_BRGT: begin
            subtract();
            taken = !cf;
          end
          acpu_pkg::OP_BRNE: begin
            subtract();
            taken = !zf;
          end
          acpu_pkg::OP_BRE: begin
            subtract();
            taken = zf;
          end
          acpu_pkg::OP_SHR:  acc = acc >> 1;
          acpu_pkg::OP_SHL:  acc = acc << 1;
          acpu_pkg::OP_XOR:  acc = acc ^ mbr;
          acpu_pkg::OP_NOT:  acc = ~acc;
          acpu_pkg::OP_OR:   acc = acc | mbr;
          acpu_pkg::OP_AND:  acc = acc & mbr;
          acpu_pkg::OP_MUL: begin
            prod = acc * mbr;
            zf   = (prod == 0);
            cf   = (prod > 255);
            vf   = cf;
            acc  = prod[acpu_pkg::DATA_W-1:0];
          end
          acpu_pkg::OP_SUB:  subtract();
          acpu_pkg::OP_ADD: begin
            acc = acc + mbr;
            zf  = (acc == 0);
            cf  = 1'b0;
            vf  = 1'b0;
          end
          acpu_pkg::OP_EOP:  halted = 1'b1;
          default: begin
            err    = 1'b1;
            halted = 1'b1;
          end
        endcase
        if (taken) pc = opnd;
      end
      r              = '0;
      r.acc_value    = acc;
      r.buffer_value = mbr;
      r.io_value     = iobr;
      r.zero_out     = zf;
      r.carry_out    = cf;
      r.overflow_out = vf;
      r.next_pc      = pc;
      r.branch_taken = taken;
      r.halt_out     = halted;
      r.error_out    = err;
      pending_state.push_back(r);
    endfunction

    function void note_fail(string msg);
      fails++;
      if (fails <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
        note_fail($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function void check_state(logic [47:0] d);
      acpu_pkg::result_t got, want;
      got = d;
      if (pending_state.size() == 0) begin
        note_fail($sformatf("state report with no instruction pending: %0h", d));
        return;
      end
      want = pending_state.pop_front();
      check_field("acc_value", 16'(want.acc_value), 16'(got.acc_value));
      check_field("buffer_value", 16'(want.buffer_value), 16'(got.buffer_value));
      check_field("io_value", 16'(want.io_value), 16'(got.io_value));
      check_field("zero_out", 16'(want.zero_out), 16'(got.zero_out));
      check_field("carry_out", 16'(want.carry_out), 16'(got.carry_out));
      check_field("overflow_out", 16'(want.overflow_out), 16'(got.overflow_out));
      check_field("next_pc", 16'(want.next_pc), 16'(got.next_pc));
      check_field("branch_taken", 16'(want.branch_taken), 16'(got.branch_taken));
      check_field("halt_out", 16'(want.halt_out), 16'(got.halt_out));
      check_field("error_out", 16'(want.error_out), 16'(got.error_out));
      check_field("pad", 16'(want.pad), 16'(got.pad));
    endfunction
  endclass

  instr_scoreboard sb = new();

  int unsigned sent_count = 0;
  int unsigned burst_left = 1;
  int unsigned idle_cycles = 0;
  int unsigned stall_pos = 0;
  bit [15:0]   stall_pat = 16'hFFFF;

  accumulator_cpu_execute DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Track both sides: execute each accepted instruction, check each state report
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.execute_instr(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_state(m_axis_tdata);
    end
  end

  // Stall the result side on a rotating pattern, reloaded whenever the low six bits of stall_pos are zero
  always @(posedge clk_i) begin
    stall_pos <= stall_pos + 1;
    if (stall_pos[5:0] == 0) begin
      if ($urandom_range(0, 3) == 0) stall_pat <= 16'hFFFF;
      else stall_pat <= 16'($urandom) | 16'($urandom);
    end
    m_axis_tready <= stall_pat[stall_pos[3:0]];
  end

  // End the run when neither side has moved a transaction for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [acpu_pkg::DATA_W-1:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Favor a few address regions so that loads hit earlier stores
  function automatic logic [acpu_pkg::OPERAND_W-1:0] rand_operand();
    case ($urandom_range(0, 3))
      0:       return 11'($urandom);
      1:       return 11'($urandom_range(0, 15));
      2:       return 11'($urandom_range(MEM_WORDS - 16, MEM_WORDS - 1));
      default: return {6'($urandom), 5'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [acpu_pkg::OPERAND_W-1:0] imm_operand();
    return {3'($urandom), rand_byte()};
  endfunction

  // Present one instruction and hold it until accepted; close the burst if due
  task automatic send_instr(input logic [acpu_pkg::OPCODE_W-1:0] code,
                            input logic [acpu_pkg::OPERAND_W-1:0] opnd);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {opnd, code};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [acpu_pkg::OPERAND_W-1:0] addr;
    int unsigned                    unused_idx;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, address aliasing and every non-halting opcode
    send_instr(acpu_pkg::OP_WB, 11'h7FF);
    send_instr(acpu_pkg::OP_WACC, 11'h000);
    send_instr(acpu_pkg::OP_WM, 11'h7FF);
    send_instr(acpu_pkg::OP_WB, 11'h000);
    send_instr(acpu_pkg::OP_RM, 11'h7FF);
    send_instr(acpu_pkg::OP_WIB, 11'h7A5);
    send_instr(acpu_pkg::OP_WIO, 11'h7FF);
    send_instr(acpu_pkg::OP_WIB_ALT, 11'h003);
    send_instr(acpu_pkg::OP_RIO, 11'h01F);
    send_instr(acpu_pkg::OP_SWAP, 11'h000);
    send_instr(acpu_pkg::OP_MUL, 11'h000);
    send_instr(acpu_pkg::OP_RACC, 11'h000);
    send_instr(acpu_pkg::OP_ADD, 11'h000);
    send_instr(acpu_pkg::OP_SUB, 11'h000);
    send_instr(acpu_pkg::OP_SHL, 11'h000);
    send_instr(acpu_pkg::OP_SHR, 11'h000);
    send_instr(acpu_pkg::OP_NOT, 11'h000);
    send_instr(acpu_pkg::OP_XOR, 11'h000);
    send_instr(acpu_pkg::OP_OR, 11'h000);
    send_instr(acpu_pkg::OP_AND, 11'h000);
    send_instr(acpu_pkg::OP_BRLT, 11'h555);
    send_instr(acpu_pkg::OP_BRGT, 11'h2AA);
    send_instr(acpu_pkg::OP_BRNE, 11'h7FE);
    send_instr(acpu_pkg::OP_BRE, 11'h001);
    send_instr(acpu_pkg::OP_BR, 11'h7FF);

    // Random: single instructions mixed with short store/load and ALU sequences
    while (sent_count < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        3: begin
          addr = rand_operand();
          send_instr(acpu_pkg::OP_WB, imm_operand());
          send_instr(acpu_pkg::OP_WM, addr);
          send_instr(acpu_pkg::OP_RM, addr);
        end
        4: begin
          addr = rand_operand();
          send_instr(acpu_pkg::OP_WIB, imm_operand());
          send_instr(acpu_pkg::OP_WIO, addr);
          send_instr(acpu_pkg::OP_SWAP, rand_operand());
          send_instr(acpu_pkg::OP_RIO, addr ^ {6'($urandom), 5'b0});
        end
        5: begin
          send_instr(acpu_pkg::OP_WB, imm_operand());
          send_instr(acpu_pkg::OP_WACC, rand_operand());
          send_instr(acpu_pkg::OP_WB, imm_operand());
          send_instr(RUN_OPS[5'($urandom_range(ALU_FIRST, 23))], rand_operand());
        end
        default: send_instr(RUN_OPS[5'($urandom_range(0, 23))], rand_operand());
      endcase
    end

    // Halt with either an end-of-program or an undecoded opcode, then keep going
    if ($urandom_range(0, 1) == 0) begin
      send_instr(acpu_pkg::OP_EOP, rand_operand());
    end else begin
      unused_idx = $urandom_range(0, 6);
      send_instr(UNUSED_OPS[3'(unused_idx)], rand_operand());
    end
    repeat (HALTED_ITEMS) send_instr(5'($urandom), 11'($urandom));
    s_axis_tvalid <= 1'b0;

    // Drain outstanding states, then give stray reports a chance to show up
    while (sb.pending_state.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
